// ===== hw/rtl/rmf_pkg.sv =====
// ============================================================================
// rmf_pkg
// Shared types, constants and sort helpers for the 3x3 raster median filter.
// ============================================================================
package rmf_pkg;

    // Sizes of the raster and of one sample.
    localparam int MAX_COLUMNS = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int GRID_COL_W  = 11;
    localparam int ROW_W       = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_NODATA_CODE  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_NODATA  = CFG_INDEX_W'(3);

    localparam logic [GRID_COL_W-1:0]  RESET_COLUMNS = GRID_COL_W'(1024);
    localparam logic [ROW_W-1:0]       RESET_ROWS    = ROW_W'(1024);
    localparam logic [SAMPLE_BITS-1:0] RESET_NODATA  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic                   RESET_SKIP    = 1'b1;

    // Window and sort network.
    localparam int WIN_N = 9;
    localparam int WIN_W = $clog2(WIN_N);
    localparam int CNT_W = $clog2(WIN_N + 1);
    localparam int KEY_W = SAMPLE_BITS + 1;

    // Sort key: drop flag on top, then the sample with its sign bit flipped,
    // so that an unsigned compare orders kept samples as signed numbers and
    // puts every dropped sample after them.
    typedef logic [KEY_W-1:0] key_t;
    typedef key_t [WIN_N-1:0] key_vec_t;

    typedef struct packed {
        logic [GRID_COL_W-1:0]  grid_columns;
        logic [ROW_W-1:0]       grid_rows;
        logic [SAMPLE_BITS-1:0] nodata_code;
        logic                   skip_nodata;
    } cfg_t;

    // Per-item flags that travel alongside the window.
    typedef struct packed {
        logic win_en;
        logic center_valid;
        logic frame_end;
    } side_t;

    function automatic key_t make_key(logic [SAMPLE_BITS-1:0] v, logic drop);
        return {drop, ~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] key_value(key_t k);
        return {~k[SAMPLE_BITS-1], k[SAMPLE_BITS-2:0]};
    endfunction

    // One round of odd-even transposition sort; the pairs are independent.
    function automatic key_vec_t oe_round(key_vec_t v, logic odd);
        key_vec_t r;
        r = v;
        for (int i = 0; i + 1 < WIN_N; i++) begin
            if ((i[0] == odd) && (v[i] > v[i+1])) begin
                r[i]   = v[i+1];
                r[i+1] = v[i];
            end
        end
        return r;
    endfunction

    // Three consecutive rounds starting with the given pair parity.
    function automatic key_vec_t three_rounds(key_vec_t v, logic first_odd);
        return oe_round(oe_round(oe_round(v, first_odd), ~first_odd), first_odd);
    endfunction

endpackage

// ===== hw/rtl/raster_median3x3_nodata.sv =====
// ============================================================================
// raster_median3x3_nodata
// 3x3 median filter over a raster stream with optional nodata exclusion.
// ============================================================================
//
//   channel   handshake                  payload
//   --------  -------------------------  ----------------------------------
//   input     sample_valid/sample_ready  sample
//   result    result_valid/result_ready  filtered, center_valid, frame_end
//   config    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One sample per cycle sustained while results are taken. The line-buffer read
// lands at the accepting edge, stage B builds the window keys, and sort stages C
// and D and the output register run the sort network and median select.
// Reset clears the counters, the window and all valid bits; the line-buffer RAMs
// are not cleared.
// A held result stalls only full stages; sample_ready drops once five wait.
//
module raster_median3x3_nodata
    import rmf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          center_valid,
    output logic                          frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cfg_t                   cfg_reg;
    logic                   win_valid, win_ready;
    key_vec_t               win_keys;
    logic [CNT_W-1:0]       win_count;
    side_t                  win_side;
    logic [SAMPLE_BITS-1:0] filtered_raw;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_columns <= RESET_COLUMNS;
            cfg_reg.grid_rows    <= RESET_ROWS;
            cfg_reg.nodata_code  <= RESET_NODATA;
            cfg_reg.skip_nodata  <= RESET_SKIP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_COLUMNS: cfg_reg.grid_columns <= cfg_data[GRID_COL_W-1:0];
                REG_GRID_ROWS:    cfg_reg.grid_rows    <= cfg_data[ROW_W-1:0];
                REG_NODATA_CODE:  cfg_reg.nodata_code  <= cfg_data[SAMPLE_BITS-1:0];
                REG_SKIP_NODATA:  cfg_reg.skip_nodata  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Line buffers and window.
    rmf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .sample    (sample),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .out_keys  (win_keys),
        .out_count (win_count),
        .out_side  (win_side)
    );

    // Sort network and output register.
    rmf_sort u_sort (
        .clk          (clk),
        .rst_n        (rst_n),
        .nodata_code  (cfg_reg.nodata_code),
        .in_valid     (win_valid),
        .in_ready     (win_ready),
        .in_keys      (win_keys),
        .in_count     (win_count),
        .in_side      (win_side),
        .out_valid    (result_valid),
        .out_ready    (result_ready),
        .filtered     (filtered_raw),
        .center_valid (center_valid),
        .frame_end    (frame_end)
    );

    assign filtered = filtered_raw;

`ifndef SYNTHESIS
    // The last sample of a frame always sits past the first row and column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_end) |-> center_valid)
        else $error("frame end reported without a window center");
`endif

endmodule

// ===== hw/rtl/rmf_ram.sv =====
// ============================================================================
// rmf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module rmf_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read ports; read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rmf_window.sv =====
// ============================================================================
// rmf_window
// Raster counters, two line-buffer RAMs and the 3x3 window; emits sort keys.
// ============================================================================
module rmf_window
    import rmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output key_vec_t               out_keys,
    output logic [CNT_W-1:0]       out_count,
    output side_t                  out_side
);

    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic                   a_valid_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic [COL_W-1:0]       a_col_reg;
    side_t                  a_side_reg, a_side_next;
    logic                   b_valid_reg;
    key_vec_t               b_keys_reg, b_keys_next;
    logic [CNT_W-1:0]       b_count_reg, b_count_next;
    side_t                  b_side_reg;
    logic [SAMPLE_BITS-1:0] win_reg [6];

    logic                   en_a, en_b, accept, move_ab;
    logic [GRID_COL_W-1:0]  cols_eff;
    logic [ROW_W-1:0]       rows_eff;
    logic                   last_col, last_row;
    logic [SAMPLE_BITS-1:0] up_rd, mid_rd;
    logic [SAMPLE_BITS-1:0] win [WIN_N];
    logic [WIN_N-1:0]       keep;

    // Two-stage pipeline: stage A waits on the RAM read, stage B holds keys.
    assign en_b     = !b_valid_reg || out_ready;
    assign move_ab  = a_valid_reg && en_b;
    assign en_a     = !a_valid_reg || en_b;
    assign accept   = in_valid && en_a;
    assign in_ready = en_a;

    // Effective frame size, saturated to the supported range.
    always_comb
    begin
        cols_eff = cfg.grid_columns;
        if (cfg.grid_columns < GRID_COL_W'(3))
        begin
            cols_eff = GRID_COL_W'(3);
        end
        else if (cfg.grid_columns > GRID_COL_W'(MAX_COLUMNS))
        begin
            cols_eff = GRID_COL_W'(MAX_COLUMNS);
        end
        rows_eff = (cfg.grid_rows < ROW_W'(3)) ? ROW_W'(3) : cfg.grid_rows;
    end

    assign last_col = GRID_COL_W'(col_reg) >= (cols_eff - GRID_COL_W'(1));
    assign last_row = row_reg >= (rows_eff - ROW_W'(1));

    // Counter advance and per-item flags.
    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        a_side_next.win_en       = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        a_side_next.center_valid = (row_reg != '0) && (col_reg != '0);
        a_side_next.frame_end    = last_col && last_row;
    end

    // Line buffers. Consecutive items always use different columns, so a
    // read never meets a pending write of the same entry.
    rmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_line_upper (
        .clk   (clk),
        .we    (move_ab),
        .waddr (a_col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    rmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_line_middle (
        .clk   (clk),
        .we    (move_ab),
        .waddr (a_col_reg),
        .wdata (a_sample_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // Assemble the window and build the sort keys.
    always_comb
    begin
        win[0] = win_reg[0];
        win[1] = win_reg[1];
        win[2] = up_rd;
        win[3] = win_reg[2];
        win[4] = win_reg[3];
        win[5] = mid_rd;
        win[6] = win_reg[4];
        win[7] = win_reg[5];
        win[8] = a_sample_reg;
        for (int i = 0; i < WIN_N; i++)
        begin
            keep[i]        = !(cfg.skip_nodata && (win[i] == cfg.nodata_code));
            b_keys_next[i] = make_key(win[i], !keep[i]);
        end
        b_count_next = CNT_W'($countones(keep));
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (move_ab)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= up_rd;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid_rd;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= a_sample_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg <= sample;
            a_col_reg    <= col_reg;
            a_side_reg   <= a_side_next;
        end
        if (move_ab)
        begin
            b_keys_reg  <= b_keys_next;
            b_count_reg <= b_count_next;
            b_side_reg  <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_keys  = b_keys_reg;
    assign out_count = b_count_reg;
    assign out_side  = b_side_reg;

`ifndef SYNTHESIS
    // A new read never targets the entry being written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && move_ab) |-> (col_reg != a_col_reg))
        else $error("line buffer read and write collide on one column");

    // A full window always has a center.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_side_reg.win_en) |-> b_side_reg.center_valid)
        else $error("window enabled without a center");
`endif

endmodule

// ===== hw/rtl/rmf_sort.sv =====
// ============================================================================
// rmf_sort
// Pipelined odd-even transposition sort of nine keys and median selection.
// ============================================================================
module rmf_sort
    import rmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_BITS-1:0] nodata_code,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  key_vec_t               in_keys,
    input  logic [CNT_W-1:0]       in_count,
    input  side_t                  in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] filtered,
    output logic                   center_valid,
    output logic                   frame_end
);

    logic                   c_valid_reg, d_valid_reg, o_valid_reg;
    key_vec_t               c_keys_reg, d_keys_reg;
    logic [CNT_W-1:0]       c_count_reg, d_count_reg;
    side_t                  c_side_reg, d_side_reg, o_side_reg;
    logic [SAMPLE_BITS-1:0] o_filtered_reg, o_filtered_next;

    logic                   en_c, en_d, en_o;
    key_vec_t               sorted;
    logic [WIN_W-1:0]       pick;

    // Each stage loads when it is empty or its content moves on.
    assign en_o     = !o_valid_reg || out_ready;
    assign en_d     = !d_valid_reg || en_o;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;

    // Last three rounds, then take the kept element at index floor(n/2).
    always_comb
    begin
        sorted = three_rounds(d_keys_reg, 1'b0);
        pick   = WIN_W'(d_count_reg >> 1);
        if (!d_side_reg.win_en || (d_count_reg == '0))
        begin
            o_filtered_next = nodata_code;
        end
        else
        begin
            o_filtered_next = key_value(sorted[pick]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_c)
            begin
                c_valid_reg <= in_valid;
            end
            if (en_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (en_o)
            begin
                o_valid_reg <= d_valid_reg;
            end
        end
    end

    // Sort stages: rounds one to three, then four to six.
    always_ff @(posedge clk)
    begin
        if (in_valid && en_c)
        begin
            c_keys_reg  <= three_rounds(in_keys, 1'b0);
            c_count_reg <= in_count;
            c_side_reg  <= in_side;
        end
        if (c_valid_reg && en_d)
        begin
            d_keys_reg  <= three_rounds(c_keys_reg, 1'b1);
            d_count_reg <= c_count_reg;
            d_side_reg  <= c_side_reg;
        end
        if (d_valid_reg && en_o)
        begin
            o_filtered_reg <= o_filtered_next;
            o_side_reg     <= d_side_reg;
        end
    end

    assign out_valid    = o_valid_reg;
    assign filtered     = o_filtered_reg;
    assign center_valid = o_side_reg.center_valid;
    assign frame_end    = o_side_reg.frame_end;

`ifndef SYNTHESIS
    // An empty output register lets the whole sort pipeline take a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !o_valid_reg |-> in_ready)
        else $error("sort pipeline stalled with an empty output");
`endif

endmodule

// ===== tb/sv/raster_median3x3_nodata_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// raster_median3x3_nodata_tb
// Self-checking bench for the 3x3 raster median filter with nodata handling.
// A short table of directed transactions covers borders, sample extremes,
// a window with no valid value, saturated sizes, a mid-row column change,
// masked register data and a bad register index. Random frames follow under
// three idling regimes, with a long receiver hold-off, a mid-frame row count
// change and one frame that opens with a row of the widest width. Every
// result is compared against its table entry or an in-bench model of the filter.
// ============================================================================
module raster_median3x3_nodata_tb
    import rmf_pkg::*;
();

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int TIMEOUT_NS    = 2000000;
    localparam int RAND_ITEMS    = 450;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 23;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          center_valid;
        logic                          frame_end;
    } filt_result_t;

    typedef enum logic [0:0] {DIR_PIXEL, DIR_REG} dir_kind_t;

    // One row of the directed table: a pixel or a register write.
    typedef struct packed {
        dir_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        filt_result_t           want;
    } dir_row_t;

    // Clock, reset and block ports.
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          sample_valid = 1'b0;
    logic                          sample_ready;
    logic signed [SAMPLE_BITS-1:0] sample       = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          center_valid;
    logic                          frame_end;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;

    // Shadow of the configuration registers.
    logic [GRID_COL_W-1:0]         cfg_cols   = RESET_COLUMNS;
    logic [ROW_W-1:0]              cfg_rows   = RESET_ROWS;
    logic signed [SAMPLE_BITS-1:0] cfg_nodata = RESET_NODATA;
    logic                          cfg_skip   = RESET_SKIP;

    // Shadow of the filter state.
    logic signed [SAMPLE_BITS-1:0] prev2_line [MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] prev1_line [MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] win_q [6];
    int unsigned                   col_pos;
    int unsigned                   row_pos;

    filt_result_t expected_q [$];
    int           fail_count      = 0;
    int           send_idle_pct   = 12;
    int           recv_idle_pct   = 83;
    int           hold_reqs       = 0;
    bit           samples_pending = 1'b0;

    dir_row_t dir_tab [DIR_ROWS];

    raster_median3x3_nodata uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .filtered     (filtered),
        .center_valid (center_valid),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reset held low from the start, released on a falling edge.
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned eff_cols();
        if (cfg_cols < 3)
            return 3;
        if (cfg_cols > MAX_COLUMNS)
            return MAX_COLUMNS;
        return 32'(cfg_cols);
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows < 3)
            return 3;
        return 32'(cfg_rows);
    endfunction

    function automatic dir_row_t pixel_row(input logic [SAMPLE_BITS-1:0] v, input logic typed,
                                           input logic [SAMPLE_BITS-1:0] f, input logic cv,
                                           input logic fe);
        dir_row_t row;
        row.kind      = DIR_PIXEL;
        row.reg_index = '0;
        row.data      = v;
        row.typed     = typed;
        row.want      = '{filtered: f, center_valid: cv, frame_end: fe};
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] d);
        dir_row_t row;
        row           = '0;
        row.kind      = DIR_REG;
        row.reg_index = idx;
        row.data      = d;
        return row;
    endfunction

    // Random pixel: nodata, values next to nodata, a small pool with ties,
    // the extremes, or anything at all.
    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0, 1, 2: return cfg_nodata;
            3:       return cfg_nodata + SAMPLE_BITS'($urandom_range(0, 2)) - 16'd1;
            4, 5:    return SAMPLE_BITS'($urandom_range(0, 6)) - 16'd3;
            6:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Register write as the block sees it: masked, bad indexes dropped.
    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_GRID_COLUMNS: cfg_cols   = d[GRID_COL_W-1:0];
            REG_GRID_ROWS:    cfg_rows   = d[ROW_W-1:0];
            REG_NODATA_CODE:  cfg_nodata = d[SAMPLE_BITS-1:0];
            REG_SKIP_NODATA:  cfg_skip   = d[0];
            default:          ;
        endcase
    endfunction

    // Filter model: one pixel in, the result for the window centered one row
    // up and one column back out, with line buffers and counters advanced.
    task automatic predict_median(input logic signed [SAMPLE_BITS-1:0] s,
                                  output filt_result_t res);
        int unsigned                   cols, rows, c, r;
        logic signed [SAMPLE_BITS-1:0] up, mid, med, hold_val;
        logic signed [SAMPLE_BITS-1:0] w [9];
        logic signed [SAMPLE_BITS-1:0] kept [9];
        int                            n, i, j;
        bit                            last_c, last_r;
        cols = eff_cols();
        rows = eff_rows();
        c    = (col_pos >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_pos;
        r    = row_pos;

        up                     = prev2_line[COL_W'(c)];
        mid                    = prev1_line[COL_W'(c)];
        prev2_line[COL_W'(c)]  = mid;
        prev1_line[COL_W'(c)]  = s;

        // Borders and empty windows give nodata.
        med = cfg_nodata;
        if (r >= 2 && c >= 2)
        begin
            w[0] = win_q[0]; w[1] = win_q[1]; w[2] = up;
            w[3] = win_q[2]; w[4] = win_q[3]; w[5] = mid;
            w[6] = win_q[4]; w[7] = win_q[5]; w[8] = s;
            n = 0;
            for (i = 0; i < 9; i++)
            begin
                if (!cfg_skip || w[i] != cfg_nodata)
                begin
                    kept[n] = w[i];
                    n++;
                end
            end
            for (i = 1; i < n; i++)
            begin
                hold_val = kept[i];
                j = i - 1;
                while (j >= 0 && kept[j] > hold_val)
                begin
                    kept[j + 1] = kept[j];
                    j--;
                end
                kept[j + 1] = hold_val;
            end
            if (n > 0)
                med = kept[n / 2];
        end

        // Shift the window; the lower index holds the older column.
        win_q[0] = win_q[1]; win_q[1] = up;
        win_q[2] = win_q[3]; win_q[3] = mid;
        win_q[4] = win_q[5]; win_q[5] = s;

        last_c           = (c >= cols - 1);
        last_r           = (r >= rows - 1);
        res.filtered     = med;
        res.center_valid = (r >= 1 && c >= 1);
        res.frame_end    = last_c && last_r;

        if (last_c)
        begin
            col_pos = 0;
            row_pos = last_r ? 0 : ((r + 1) & 32'hFFFF);
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    // Offer one pixel, idling cycle by cycle before it, and hold it until the
    // transaction completes. The expectation is queued when it is offered.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v, input logic typed,
                               input filt_result_t want, output bit fe);
        filt_result_t pred;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        predict_median(v, pred);
        fe = pred.frame_end;
        expected_q.insert(expected_q.size(), typed ? want : pred);
        samples_pending = 1'b1;
        sample       <= v;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        @(negedge clk);
    endtask

    // Register write, only once every queued result has come out.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        if (samples_pending)
        begin
            sample_valid <= 1'b0;
            while (expected_q.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            samples_pending = 1'b0;
        end
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, d);
        @(negedge clk);
    endtask

    // Random frames; sometimes the first one gets a column count no larger than
    // before or a new row count partway through.
    task automatic run_frames(input int nfr, inout int count);
        int done, k, frame_len, change_at;
        bit fe;
        done      = 0;
        k         = 0;
        frame_len = eff_cols() * eff_rows();
        change_at = ($urandom_range(3) == 0) ? int'($urandom_range(1, frame_len - 1)) : -1;
        while (done < nfr)
        begin
            if (k == change_at)
            begin
                if ($urandom_range(1))
                    cfg_write(REG_GRID_COLUMNS,
                              {5'($urandom), GRID_COL_W'($urandom_range(3, eff_cols()))});
                else
                    cfg_write(REG_GRID_ROWS, ROW_W'($urandom_range(0, 8)));
            end
            send_sample(rand_sample(), 1'b0, '0, fe);
            k++;
            count++;
            if (fe)
                done++;
        end
    endtask

    // Receiver: random ready, or a long counted hold-off on request.
    initial
    begin : receiver
        int hold_cnt;
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_reqs)
            begin
                result_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(negedge clk);
                holds_done++;
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        filt_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: filtered %h center_valid %b frame_end %b",
                             filtered, center_valid, frame_end);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (filtered !== want.filtered || center_valid !== want.center_valid ||
                    frame_end !== want.frame_end)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch: filtered %h/%h center_valid %b/%b frame_end %b/%b",
                                 want.filtered, filtered, want.center_valid, center_valid,
                                 want.frame_end, frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        int i, regime, count, target, cols_v, rows_v;
        logic [SAMPLE_BITS-1:0] nd_v;
        bit fe;
        int send_pcts [3];
        int recv_pcts [3];
        send_pcts = '{12, 83, 0};
        recv_pcts = '{83, 12, 0};

        for (i = 0; i < MAX_COLUMNS; i++)
        begin
            prev2_line[i] = '0;
            prev1_line[i] = '0;
        end
        for (i = 0; i < 6; i++)
            win_q[i] = '0;
        col_pos = 0;
        row_pos = 0;

        // Directed table. Row 0 starts under the reset sizes; the column
        // count then drops to a saturated 3 while the row is at column 2,
        // which ends that row on the next pixel.
        dir_tab[0]  = pixel_row(16'h7FFF, 1'b1, 16'h8000, 1'b0, 1'b0);
        dir_tab[1]  = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b0, 1'b0);
        dir_tab[2]  = reg_row(REG_GRID_COLUMNS, 16'h0002);
        dir_tab[3]  = reg_row(REG_GRID_ROWS, 16'h0000);
        dir_tab[4]  = pixel_row(16'h0001, 1'b1, 16'h8000, 1'b0, 1'b0);
        dir_tab[5]  = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b0, 1'b0);
        dir_tab[6]  = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b1, 1'b0);
        dir_tab[7]  = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b1, 1'b0);
        dir_tab[8]  = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b0, 1'b0);
        dir_tab[9]  = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b1, 1'b0);
        // Only two values survive the nodata drop; the upper one wins.
        dir_tab[10] = pixel_row(16'h8000, 1'b1, 16'h7FFF, 1'b1, 1'b1);
        // A frame of nodata only; the last window has no valid value.
        for (i = 11; i < 19; i++)
            dir_tab[i] = pixel_row(16'h8000, 1'b0, '0, 1'b0, 1'b0);
        dir_tab[19] = pixel_row(16'h8000, 1'b1, 16'h8000, 1'b1, 1'b1);
        dir_tab[20] = reg_row(4'hF, 16'h1234);
        dir_tab[21] = reg_row(REG_SKIP_NODATA, 16'hFFFE);
        dir_tab[22] = reg_row(REG_NODATA_CODE, 16'h7FFF);

        wait (rst_n);
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].kind == DIR_REG)
                cfg_write(dir_tab[i].reg_index, dir_tab[i].data);
            else
                send_sample(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want, fe);
        end

        // Random frames under each idling regime.
        for (regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = send_pcts[regime];
            recv_idle_pct = recv_pcts[regime];
            count  = 0;
            target = RAND_ITEMS / 3;

            if (regime == 2)
            begin
                // Receiver holds off while pixels keep coming.
                cfg_write(REG_GRID_COLUMNS, 16'd8);
                cfg_write(REG_GRID_ROWS, 16'd5);
                hold_reqs++;
                run_frames(2, count);

                // Tallest frame, cut short by a smaller row count mid-frame.
                cfg_write(REG_GRID_COLUMNS, 16'd3);
                cfg_write(REG_GRID_ROWS, 16'hFFFF);
                for (i = 0; i < 18; i++)
                    send_sample(rand_sample(), 1'b0, '0, fe);
                cfg_write(REG_GRID_ROWS, 16'd2);
                run_frames(1, count);

                // Widest row: all column bits set saturates to the maximum.
                // The column count then drops back to 3 to keep the frame short.
                cfg_write(REG_GRID_COLUMNS, 16'hFFFF);
                cfg_write(REG_GRID_ROWS, 16'd3);
                for (i = 0; i < MAX_COLUMNS; i++)
                    send_sample(rand_sample(), 1'b0, '0, fe);
                cfg_write(REG_GRID_COLUMNS, 16'd3);
                run_frames(1, count);
                count = 0;
            end

            while (count < target)
            begin
                cols_v = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
                rows_v = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
                case ($urandom_range(3))
                    0:       nd_v = 16'h8000;
                    1:       nd_v = 16'h7FFF;
                    2:       nd_v = 16'h0000;
                    default: nd_v = SAMPLE_BITS'($urandom);
                endcase
                cfg_write(REG_GRID_COLUMNS, {5'($urandom), GRID_COL_W'(cols_v)});
                cfg_write(REG_GRID_ROWS, ROW_W'(rows_v));
                cfg_write(REG_NODATA_CODE, nd_v);
                cfg_write(REG_SKIP_NODATA, {15'($urandom), 1'($urandom)});
                if ($urandom_range(3) == 0)
                    cfg_write(CFG_INDEX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
                run_frames($urandom_range(1, 3), count);
            end
        end

        // Let every result drain, then report.
        sample_valid <= 1'b0;
        cfg_valid    <= 1'b0;
        i = 0;
        while (expected_q.size() != 0 && i < DRAIN_LIMIT)
        begin
            @(negedge clk);
            i++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_q.size() != 0)
            $display("%0d expected results never arrived", expected_q.size());
        if (fail_count == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
